### rtl/rpe_pkg.sv
// shared constants, types and table functions of the rotary position embedding pipeline
package rpe_pkg;

    localparam int VECTOR_DIM    = 256;
    localparam int POSITION_BITS = 20;

    // pipeline depths
    localparam int DIV_STEPS    = 32;
    localparam int EXP_STEPS    = 24;
    localparam int CORDIC_STEPS = 24;

    // datapath widths
    localparam int M_W       = 33;
    localparam int PROD_W    = POSITION_BITS + M_W;
    localparam int ANG_W     = 35;
    localparam int MOD_STEPS = PROD_W - (ANG_W - 1);
    localparam int Z_W       = 28;
    localparam int CS_W      = 33;

    // angle constants
    localparam logic [ANG_W-1:0]      TWO_PI_Q32        = 35'd26986075409;
    localparam logic signed [Z_W-1:0] HALF_PI_Q24       = 28'sd26353589;
    localparam logic signed [Z_W-1:0] PI_Q24            = 28'sd52707179;
    localparam logic signed [Z_W-1:0] THREE_HALF_PI_Q24 = 28'sd79060768;
    localparam logic signed [Z_W-1:0] TWO_PI_Q24        = 28'sd105414358;
    localparam logic signed [CS_W-1:0] CORDIC_GAIN_Q30  = 33'sd652032874;

    localparam logic signed [Z_W-1:0] ATAN_Q24 [8] = '{
        28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
        28'sd1047214,  28'sd524117,  28'sd262123,  28'sd131069
    };

    // configuration register indexes
    localparam logic [0:0] REG_THETA_LOG2    = 1'b0;
    localparam logic [0:0] REG_ROTATED_WIDTH = 1'b1;

    // sideband that travels with each item
    typedef struct packed {
        logic                     valid;
        logic                     pass;
        logic [POSITION_BITS-1:0] position;
        logic signed [15:0]       x_even;
        logic signed [15:0]       x_odd;
    } rpe_side_t;

    typedef logic [EXP_STEPS-1:0][31:0] rpe_fac_t;

    // floor square root, evaluated at elaboration only
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] res;
        logic [63:0] bit_v;
        n     = n_in;
        res   = 64'd0;
        bit_v = 64'h4000_0000_0000_0000;
        for (int i = 0; i < 32; i++) begin
            if (bit_v > n) bit_v = bit_v >> 2;
        end
        for (int i = 0; i < 32; i++) begin
            if (bit_v != 64'd0) begin
                if (n >= res + bit_v) begin
                    n   = n - (res + bit_v);
                    res = (res >> 1) + bit_v;
                end
                else begin
                    res = res >> 1;
                end
                bit_v = bit_v >> 2;
            end
        end
        return res;
    endfunction

    // factors 2^(-2^-i) in Q32 for fraction bits 1..24
    function automatic rpe_fac_t make_factors();
        rpe_fac_t    tab;
        logic [63:0] t;
        t = isqrt64(64'h8000_0000_0000_0000);
        for (int i = 0; i < EXP_STEPS; i++) begin
            tab[i] = t[31:0];
            t      = isqrt64({t[31:0], 32'd0});
        end
        return tab;
    endfunction

    // cordic arctangent step in Q24
    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic [2:0] idx;
        idx = i[2:0];
        if (i < 8) return ATAN_Q24[idx];
        return Z_W'(1 << (24 - i));
    endfunction

endpackage

### rtl/rpe_freq.sv
// frequency stages: exponent divide and exp2 of the fraction by factor products
module rpe_freq (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  rpe_pkg::rpe_side_t         side_in,
    input  logic [6:0]                 pair_index,
    input  logic [31:0]                theta_log2,
    input  logic [8:0]                 rotated_width,
    output rpe_pkg::rpe_side_t         side_out,
    output logic [rpe_pkg::M_W-1:0]    m_out,
    output logic [7:0]                 k_out
);
    import rpe_pkg::*;

    localparam rpe_fac_t FACTOR_Q32 = make_factors();

    logic [7:0]  pair2;
    logic [39:0] num;
    rpe_side_t   side0_next;

    rpe_side_t   side0_reg;
    logic [8:0]  rem0_reg;
    logic [31:0] w0_reg;

    rpe_side_t   div_side_reg [DIV_STEPS];
    logic [8:0]  div_rem_reg  [DIV_STEPS];
    logic [31:0] div_w_reg    [DIV_STEPS];

    rpe_side_t      exp_side_reg [EXP_STEPS];
    logic [M_W-1:0] exp_m_reg    [EXP_STEPS];
    logic [23:0]    exp_r_reg    [EXP_STEPS];
    logic [7:0]     exp_k_reg    [EXP_STEPS];

    // numerator 2*pair*theta and pass-through decision
    always_comb
    begin
        pair2      = {pair_index, 1'b0};
        num        = 40'(pair2) * 40'(theta_log2);
        side0_next = side_in;
        side0_next.pass = !(({1'b0, pair2} < rotated_width) && (int'(pair2) < VECTOR_DIM));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) side0_reg <= '0;
        else if (adv) side0_reg <= side0_next;
    end

    // quotient fits 32 bits, so the top byte preloads the remainder
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem0_reg <= {1'b0, num[39:32]};
            w0_reg   <= num[31:0];
        end
    end

    // restoring divider, one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        rpe_side_t   s_src;
        logic [8:0]  r_src;
        logic [31:0] w_src;
        logic [9:0]  r_try;
        logic        ge;
        if (j == 0)
        begin : g_first
            assign s_src = side0_reg;
            assign r_src = rem0_reg;
            assign w_src = w0_reg;
        end
        else
        begin : g_rest
            assign s_src = div_side_reg[j-1];
            assign r_src = div_rem_reg[j-1];
            assign w_src = div_w_reg[j-1];
        end
        assign r_try = {r_src, w_src[31]};
        assign ge    = r_try >= {1'b0, rotated_width};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) div_side_reg[j] <= '0;
            else if (adv) div_side_reg[j] <= s_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                div_rem_reg[j] <= ge ? 9'(r_try - {1'b0, rotated_width}) : r_try[8:0];
                div_w_reg[j]   <= {w_src[30:0], ge};
            end
        end
    end

    // exp2 of the negated fraction, one factor per stage
    for (genvar i = 0; i < EXP_STEPS; i++)
    begin : g_exp
        rpe_side_t       s_src;
        logic [M_W-1:0]  m_src;
        logic [23:0]     r_src;
        logic [7:0]      k_src;
        logic [M_W+31:0] prod;
        if (i == 0)
        begin : g_first
            assign s_src = div_side_reg[DIV_STEPS-1];
            assign m_src = M_W'(64'h1_0000_0000);
            assign r_src = div_w_reg[DIV_STEPS-1][23:0];
            assign k_src = div_w_reg[DIV_STEPS-1][31:24];
        end
        else
        begin : g_rest
            assign s_src = exp_side_reg[i-1];
            assign m_src = exp_m_reg[i-1];
            assign r_src = exp_r_reg[i-1];
            assign k_src = exp_k_reg[i-1];
        end
        assign prod = (M_W+32)'(m_src) * (M_W+32)'(FACTOR_Q32[i]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) exp_side_reg[i] <= '0;
            else if (adv) exp_side_reg[i] <= s_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                exp_m_reg[i] <= r_src[EXP_STEPS-1-i] ? M_W'(prod >> 32) : m_src;
                exp_r_reg[i] <= r_src;
                exp_k_reg[i] <= k_src;
            end
        end
    end

    assign side_out = exp_side_reg[EXP_STEPS-1];
    assign m_out    = exp_m_reg[EXP_STEPS-1];
    assign k_out    = exp_k_reg[EXP_STEPS-1];

endmodule

### rtl/rpe_angle.sv
// angle stages: position times frequency, shift, reduction modulo 2*pi and quadrant fold
module rpe_angle (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             adv,
    input  rpe_pkg::rpe_side_t               side_in,
    input  logic [rpe_pkg::M_W-1:0]          m_in,
    input  logic [7:0]                       k_in,
    output rpe_pkg::rpe_side_t               side_out,
    output logic signed [rpe_pkg::Z_W-1:0]   z_out,
    output logic                             neg_out
);
    import rpe_pkg::*;

    rpe_side_t         prod_side_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [7:0]        k_reg;

    rpe_side_t         sh_side_reg;
    logic [PROD_W-1:0] sh_reg;

    rpe_side_t         mod_side_reg [MOD_STEPS];
    logic [PROD_W-1:0] mod_reg      [MOD_STEPS];

    rpe_side_t             fold_side_reg;
    logic signed [Z_W-1:0] z_reg;
    logic                  neg_reg;

    logic signed [Z_W-1:0] a_q24;
    logic signed [Z_W-1:0] z_next;
    logic                  neg_next;

    // control valid bits of the product and shift stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_side_reg <= '0;
            sh_side_reg   <= '0;
        end
        else if (adv)
        begin
            prod_side_reg <= side_in;
            sh_side_reg   <= prod_side_reg;
        end
    end

    // position times frequency, then the integer-part shift
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= PROD_W'(side_in.position) * PROD_W'(m_in);
            k_reg    <= k_in;
            sh_reg   <= prod_reg >> k_reg;
        end
    end

    // reduction modulo 2*pi, one shifted compare-subtract per stage
    for (genvar j = 0; j < MOD_STEPS; j++)
    begin : g_mod
        localparam logic [PROD_W-1:0] STEP_C = PROD_W'(TWO_PI_Q32) << (MOD_STEPS - 1 - j);
        rpe_side_t         s_src;
        logic [PROD_W-1:0] v_src;
        if (j == 0)
        begin : g_first
            assign s_src = sh_side_reg;
            assign v_src = sh_reg;
        end
        else
        begin : g_rest
            assign s_src = mod_side_reg[j-1];
            assign v_src = mod_reg[j-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) mod_side_reg[j] <= '0;
            else if (adv) mod_side_reg[j] <= s_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv) mod_reg[j] <= (v_src >= STEP_C) ? v_src - STEP_C : v_src;
        end
    end

    // fold into [-pi/2, pi/2], a fold by pi flips both outputs
    always_comb
    begin
        a_q24 = $signed({1'b0, mod_reg[MOD_STEPS-1][ANG_W-1:8]});
        if (a_q24 < HALF_PI_Q24)
        begin
            z_next   = a_q24;
            neg_next = 1'b0;
        end
        else if (a_q24 < THREE_HALF_PI_Q24)
        begin
            z_next   = a_q24 - PI_Q24;
            neg_next = 1'b1;
        end
        else
        begin
            z_next   = a_q24 - TWO_PI_Q24;
            neg_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) fold_side_reg <= '0;
        else if (adv) fold_side_reg <= mod_side_reg[MOD_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z_reg   <= z_next;
            neg_reg <= neg_next;
        end
    end

    assign side_out = fold_side_reg;
    assign z_out    = z_reg;
    assign neg_out  = neg_reg;

endmodule

### rtl/rpe_cordic.sv
// unrolled cordic in rotation mode, one micro-rotation per stage
module rpe_cordic (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  rpe_pkg::rpe_side_t              side_in,
    input  logic signed [rpe_pkg::Z_W-1:0]  z_in,
    input  logic                            neg_in,
    output rpe_pkg::rpe_side_t              side_out,
    output logic signed [rpe_pkg::CS_W-1:0] cos_out,
    output logic signed [rpe_pkg::CS_W-1:0] sin_out,
    output logic                            neg_out
);
    import rpe_pkg::*;

    rpe_side_t              c_side_reg [CORDIC_STEPS];
    logic signed [CS_W-1:0] c_x_reg    [CORDIC_STEPS];
    logic signed [CS_W-1:0] c_y_reg    [CORDIC_STEPS];
    logic signed [Z_W-1:0]  c_z_reg    [CORDIC_STEPS];
    logic                   c_neg_reg  [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        localparam logic signed [Z_W-1:0] ATAN_I = atan_step(i);
        rpe_side_t              s_src;
        logic signed [CS_W-1:0] x_src;
        logic signed [CS_W-1:0] y_src;
        logic signed [Z_W-1:0]  z_src;
        logic                   n_src;
        logic signed [CS_W-1:0] dx;
        logic signed [CS_W-1:0] dy;
        if (i == 0)
        begin : g_first
            assign s_src = side_in;
            assign x_src = CORDIC_GAIN_Q30;
            assign y_src = '0;
            assign z_src = z_in;
            assign n_src = neg_in;
        end
        else
        begin : g_rest
            assign s_src = c_side_reg[i-1];
            assign x_src = c_x_reg[i-1];
            assign y_src = c_y_reg[i-1];
            assign z_src = c_z_reg[i-1];
            assign n_src = c_neg_reg[i-1];
        end
        // arithmetic shifts floor toward minus infinity
        assign dx = y_src >>> i;
        assign dy = x_src >>> i;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) c_side_reg[i] <= '0;
            else if (adv) c_side_reg[i] <= s_src;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (z_src >= 0)
                begin
                    c_x_reg[i] <= x_src - dx;
                    c_y_reg[i] <= y_src + dy;
                    c_z_reg[i] <= z_src - ATAN_I;
                end
                else
                begin
                    c_x_reg[i] <= x_src + dx;
                    c_y_reg[i] <= y_src - dy;
                    c_z_reg[i] <= z_src + ATAN_I;
                end
                c_neg_reg[i] <= n_src;
            end
        end
    end

    assign side_out = c_side_reg[CORDIC_STEPS-1];
    assign cos_out  = c_x_reg[CORDIC_STEPS-1];
    assign sin_out  = c_y_reg[CORDIC_STEPS-1];
    assign neg_out  = c_neg_reg[CORDIC_STEPS-1];

endmodule

### rtl/rpe_rotate.sv
// rotation stages: quadrant sign, four products, round, saturate and output register
module rpe_rotate (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            adv,
    input  rpe_pkg::rpe_side_t              side_in,
    input  logic signed [rpe_pkg::CS_W-1:0] cos_in,
    input  logic signed [rpe_pkg::CS_W-1:0] sin_in,
    input  logic                            neg_in,
    output logic                            valid_out,
    output logic signed [15:0]              y_even,
    output logic signed [15:0]              y_odd
);
    import rpe_pkg::*;

    localparam int P_W = CS_W + 16;
    localparam int S_W = P_W + 2;

    rpe_side_t              sg_side_reg;
    logic signed [CS_W-1:0] c_reg;
    logic signed [CS_W-1:0] s_reg;

    rpe_side_t             mul_side_reg;
    logic signed [P_W-1:0] p_ec_reg;
    logic signed [P_W-1:0] p_os_reg;
    logic signed [P_W-1:0] p_es_reg;
    logic signed [P_W-1:0] p_oc_reg;

    logic                  out_valid_reg;
    logic signed [15:0]    y_even_reg;
    logic signed [15:0]    y_odd_reg;

    logic signed [S_W-1:0] sum_e;
    logic signed [S_W-1:0] sum_o;

    function automatic logic signed [15:0] sat16(input logic signed [S_W-1:0] v);
        if (v > S_W'(32767)) return 16'sh7fff;
        if (v < -S_W'(32768)) return 16'sh8000;
        return v[15:0];
    endfunction

    // control valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_side_reg   <= '0;
            mul_side_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sg_side_reg   <= side_in;
            mul_side_reg  <= sg_side_reg;
            out_valid_reg <= mul_side_reg.valid;
        end
    end

    // sums scaled from Q30 back to the input format, rounded half up with a floor shift
    always_comb
    begin
        sum_e = (S_W'(p_ec_reg) - S_W'(p_os_reg) + S_W'(64'sd536870912)) >>> 30;
        sum_o = (S_W'(p_es_reg) + S_W'(p_oc_reg) + S_W'(64'sd536870912)) >>> 30;
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg    <= neg_in ? -cos_in : cos_in;
            s_reg    <= neg_in ? -sin_in : sin_in;
            p_ec_reg <= P_W'(sg_side_reg.x_even) * P_W'(c_reg);
            p_os_reg <= P_W'(sg_side_reg.x_odd) * P_W'(s_reg);
            p_es_reg <= P_W'(sg_side_reg.x_even) * P_W'(s_reg);
            p_oc_reg <= P_W'(sg_side_reg.x_odd) * P_W'(c_reg);
            y_even_reg <= mul_side_reg.pass ? mul_side_reg.x_even : sat16(sum_e);
            y_odd_reg  <= mul_side_reg.pass ? mul_side_reg.x_odd  : sat16(sum_o);
        end
    end

    assign valid_out = out_valid_reg;
    assign y_even    = y_even_reg;
    assign y_odd     = y_odd_reg;

endmodule

### rtl/rotary_position_embedding.sv
// rotary position embedding for interleaved pairs: a pipeline from input to output register
// throughput one item per cycle; the whole pipeline advances together when the output is free
// stages: 1 numerator, 32 divider bits, 24 exp2 factors, 22 angle and reduction, 24 cordic, 3 rotate
// reset clears all valid bits and loads theta_log2 = 222930869 and rotated_width = 256
module rotary_position_embedding (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] x_even,
    input  logic signed [15:0] x_odd,
    input  logic [6:0]         pair_index,
    input  logic [rpe_pkg::POSITION_BITS-1:0] position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] y_even,
    output logic signed [15:0] y_odd,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [0:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import rpe_pkg::*;

    logic        adv;
    logic [31:0] theta_log2_reg;
    logic [8:0]  rotated_width_reg;
    rpe_side_t   side_in;

    rpe_side_t             f_side;
    logic [M_W-1:0]        f_m;
    logic [7:0]            f_k;
    rpe_side_t             a_side;
    logic signed [Z_W-1:0] a_z;
    logic                  a_neg;
    rpe_side_t              c_side;
    logic signed [CS_W-1:0] c_cos;
    logic signed [CS_W-1:0] c_sin;
    logic                   c_neg;

    // global advance when the output register is empty or being taken
    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_log2_reg    <= 32'd222930869;
            rotated_width_reg <= 9'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_THETA_LOG2:    theta_log2_reg    <= cfg_data;
                REG_ROTATED_WIDTH: rotated_width_reg <= cfg_data[8:0];
            endcase
        end
    end

    // item entering the pipeline
    always_comb
    begin
        side_in.valid    = in_valid;
        side_in.pass     = 1'b0;
        side_in.position = position;
        side_in.x_even   = x_even;
        side_in.x_odd    = x_odd;
    end

    rpe_freq u_freq (
        .clk           (clk),
        .rst_n         (rst_n),
        .adv           (adv),
        .side_in       (side_in),
        .pair_index    (pair_index),
        .theta_log2    (theta_log2_reg),
        .rotated_width (rotated_width_reg),
        .side_out      (f_side),
        .m_out         (f_m),
        .k_out         (f_k)
    );

    rpe_angle u_angle (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .side_in  (f_side),
        .m_in     (f_m),
        .k_in     (f_k),
        .side_out (a_side),
        .z_out    (a_z),
        .neg_out  (a_neg)
    );

    rpe_cordic u_cordic (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .side_in  (a_side),
        .z_in     (a_z),
        .neg_in   (a_neg),
        .side_out (c_side),
        .cos_out  (c_cos),
        .sin_out  (c_sin),
        .neg_out  (c_neg)
    );

    rpe_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .side_in   (c_side),
        .cos_in    (c_cos),
        .sin_in    (c_sin),
        .neg_in    (c_neg),
        .valid_out (out_valid),
        .y_even    (y_even),
        .y_odd     (y_odd)
    );

endmodule

### bench/tb.sv
// testbench for the rotary position embedding block: predicts every rotated pair and checks it
`timescale 1ns / 1ps

module tb;
    import rpe_pkg::*;

    // one rotated pair as it leaves the block
    typedef struct {
        logic signed [15:0] ye;
        logic signed [15:0] yo;
    } rot_pair_t;

    // predicts rotated pairs and holds the ones still owed by the block
    class rotation_board;
        logic [31:0]     theta_log2;
        logic [8:0]      rot_width;
        rot_pair_t       owed[$];
        int              errors;
        longint unsigned exp_factor[24];
        longint          atan_q24[8];

        function new();
            longint unsigned t;
            theta_log2 = 32'd222930869;
            rot_width  = 9'd256;
            errors     = 0;
            t = root_floor(64'h8000_0000_0000_0000);
            for (int i = 0; i < 24; i++)
            begin
                exp_factor[i] = t;
                t = root_floor(t << 32);
            end
            atan_q24 = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069};
        endfunction

        // floor square root, digit by digit
        function longint unsigned root_floor(longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > n) b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        function void write_reg(logic [0:0] idx, logic [31:0] data);
            if (idx == REG_THETA_LOG2)
                theta_log2 = data;
            else
                rot_width = data[8:0];
        endfunction

        function longint clamp16(longint v);
            if (v > 32767) return 32767;
            if (v < -32768) return -32768;
            return v;
        endfunction

        // angle from position and pair, then cordic and rotation
        function void note_input(logic signed [15:0] x0, logic signed [15:0] x1,
                                 logic [6:0] pair, logic [POSITION_BITS-1:0] pos);
            longint unsigned e, k, r, m, ang, two_pair;
            longint          a, z, cx, cy, step, dx, dy, x0l, x1l;
            bit              neg;
            rot_pair_t       res;
            x0l = x0;
            x1l = x1;
            two_pair = 2 * longint'(pair);
            res.ye = x0;
            res.yo = x1;
            if (two_pair < rot_width && two_pair < VECTOR_DIM)
            begin
                e = (two_pair * longint'(theta_log2)) / longint'(rot_width);
                k = e >> 24;
                r = e & 64'hFF_FFFF;
                m = 64'h1_0000_0000;
                for (int i = 1; i <= 24; i++)
                    if ((r >> (24 - i)) & 1) m = (m * exp_factor[i-1]) >> 32;
                ang = (k >= 64) ? 0 : ((longint'(pos) * m) >> k);
                ang = ang % 64'd26986075409;
                a = ang >> 8;
                neg = 0;
                // fold into the cordic range, a fold by pi flips the signs
                if (a < 26353589)
                    z = a;
                else if (a < 79060768)
                begin
                    z = a - 52707179;
                    neg = 1;
                end
                else
                    z = a - 2 * 52707179;
                cx = 652032874;
                cy = 0;
                for (int i = 0; i < 24; i++)
                begin
                    step = (i < 8) ? atan_q24[i] : (longint'(1) << (24 - i));
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (z >= 0)
                    begin
                        cx = cx - dx;
                        cy = cy + dy;
                        z  = z - step;
                    end
                    else
                    begin
                        cx = cx + dx;
                        cy = cy - dy;
                        z  = z + step;
                    end
                end
                if (neg)
                begin
                    cx = -cx;
                    cy = -cy;
                end
                res.ye = 16'(clamp16((x0l * cx - x1l * cy + (longint'(1) << 29)) >>> 30));
                res.yo = 16'(clamp16((x0l * cy + x1l * cx + (longint'(1) << 29)) >>> 30));
            end
            owed.push_back(res);
        endfunction

        function void check_result(logic signed [15:0] ye, logic signed [15:0] yo);
            rot_pair_t want;
            if (owed.size() == 0)
            begin
                $error("unexpected item: y_even %0d y_odd %0d", ye, yo);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (ye !== want.ye)
            begin
                $error("y_even expected %0d actual %0d", want.ye, ye);
                errors++;
            end
            if (yo !== want.yo)
            begin
                $error("y_odd expected %0d actual %0d", want.yo, yo);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic signed [15:0]       x_even;
    logic signed [15:0]       x_odd;
    logic [6:0]               pair_index;
    logic [POSITION_BITS-1:0] position;
    logic                     out_valid;
    logic                     out_ready;
    logic signed [15:0]       y_even;
    logic signed [15:0]       y_odd;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [0:0]               cfg_index;
    logic [31:0]              cfg_data;

    rotation_board board;
    bit            send_steady;
    bit            recv_steady;
    int            hold_request;

    rotary_position_embedding uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .x_even     (x_even),
        .x_odd      (x_odd),
        .pair_index (pair_index),
        .position   (position),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .y_even     (y_even),
        .y_odd      (y_odd),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // watchdog
    initial
    begin
        #50_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // receiver: checks accepted items, stalls at random or for a long hold
    initial
    begin
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_result(y_even, y_odd);
            if (hold_request != 0)
            begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= recv_steady || ($urandom_range(99) >= 19);
        end
    end

    // offer one item and wait for it to be taken
    task automatic send_item(logic signed [15:0] x0, logic signed [15:0] x1,
                             logic [6:0] pair, logic [POSITION_BITS-1:0] pos);
        in_valid   <= 1'b1;
        x_even     <= x0;
        x_odd      <= x1;
        pair_index <= pair;
        position   <= pos;
        do @(posedge clk); while (!in_ready);
        board.note_input(x0, x1, pair, pos);
        if (!send_steady && $urandom_range(99) < 23)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.owed.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // register write, only with the pipeline empty
    task automatic write_reg(logic [0:0] idx, logic [31:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.write_reg(idx, data);
        @(posedge clk);
    endtask

    // random item, positions small in half the draws and full range in the rest
    task automatic send_random();
        logic [POSITION_BITS-1:0] pos;
        case ($urandom_range(3))
            0: pos = POSITION_BITS'($urandom_range(15));
            1: pos = POSITION_BITS'($urandom_range(4095));
            default: pos = POSITION_BITS'($urandom);
        endcase
        send_item(16'($urandom), 16'($urandom), 7'($urandom_range(127)), pos);
    endtask

    task automatic random_run(int n);
        repeat (n) send_random();
    endtask

    initial
    begin
        board = new();
        send_steady = 0;
        recv_steady = 0;
        hold_request = 0;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        x_even     <= '0;
        x_odd      <= '0;
        pair_index <= '0;
        position   <= '0;
        cfg_valid  <= 1'b0;
        cfg_index  <= REG_THETA_LOG2;
        cfg_data   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes at reset settings
        send_item(16'sh7fff, 16'sh7fff, 7'd0, '0);
        send_item(-16'sh8000, -16'sh8000, 7'd0, 20'd1);
        send_item(16'sh7fff, -16'sh8000, 7'd0, 20'd3);
        send_item(-16'sh8000, 16'sh7fff, 7'd1, '1);
        send_item(16'sh1000, 16'sh0000, 7'd0, 20'd2);
        send_item(16'sh1000, 16'sh1000, 7'd0, 20'd5);
        send_item(16'sh0000, 16'sh0000, 7'd64, '1);
        send_item(16'sh7fff, 16'sh0001, 7'd127, '1);
        send_item(-16'sh0001, 16'sh5555, 7'd127, 20'd0);
        send_item(16'shaaaa, 16'sh5555, 7'd63, 20'h55555);
        send_item(16'sh5555, 16'shaaaa, 7'd42, 20'haaaaa);
        send_item(16'sh1234, -16'sh1234, 7'd10, '1);
        random_run(200);

        // long receiver hold while the sender keeps offering
        send_steady = 1;
        hold_request = 400;
        random_run(250);
        send_steady = 0;
        // sender pause until all results are back
        drain();
        recv_steady = 1;
        random_run(120);
        recv_steady = 0;

        // theta of one, narrowest width
        write_reg(REG_THETA_LOG2, 32'd0);
        write_reg(REG_ROTATED_WIDTH, 32'd2);
        send_item(16'sh7fff, -16'sh8000, 7'd0, '1);
        send_item(16'sh7fff, -16'sh8000, 7'd1, '1);
        random_run(150);

        // largest theta, full width
        write_reg(REG_THETA_LOG2, 32'hffff_ffff);
        write_reg(REG_ROTATED_WIDTH, 32'd256);
        send_item(16'sh7fff, 16'sh7fff, 7'd127, '1);
        random_run(150);

        // zero width passes all pairs, upper data bits ignored
        write_reg(REG_ROTATED_WIDTH, 32'hffff_fe00);
        random_run(100);

        // odd width
        write_reg(REG_THETA_LOG2, 32'd16777216);
        write_reg(REG_ROTATED_WIDTH, 32'd7);
        send_item(16'sh4000, 16'sh2000, 7'd3, 20'd9);
        send_item(16'sh4000, 16'sh2000, 7'd4, 20'd9);
        random_run(150);

        // width beyond the head
        write_reg(REG_ROTATED_WIDTH, 32'd511);
        random_run(150);

        // random settings
        repeat (3)
        begin
            write_reg(REG_THETA_LOG2, $urandom_range(32'h0800_0000));
            write_reg(REG_ROTATED_WIDTH, 2 * $urandom_range(128, 1));
            random_run(100);
        end

        drain();
        repeat (120) @(posedge clk);
        if (board.errors == 0 && board.owed.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

### sim.f
rtl/rpe_pkg.sv
rtl/rpe_freq.sv
rtl/rpe_angle.sv
rtl/rpe_cordic.sv
rtl/rpe_rotate.sv
rtl/rotary_position_embedding.sv
bench/tb.sv
